### design/otc_pkg.sv
// ----------------------------------------------------------------------------
// otc_pkg
// Shared constants, codes and controller/datapath interface types for the
// oscillator trim calibrator.
// ----------------------------------------------------------------------------
package otc_pkg;

    localparam int MAX_ROUNDS_DEF  = 63;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int PERIOD_W    = 20;
    localparam int TICK_W      = 8;
    localparam int TRIM_W      = 8;
    localparam int TARGET_W    = 16;
    localparam int BAND_W      = TARGET_W + 1;
    localparam int MARGIN_W    = 9;
    localparam int DIV_CNT_W   = $clog2(PERIOD_W);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = PERIOD_W;
    localparam int STATUS_W    = 2;

    // floor(t / 200) == (t * MARGIN_MUL) >> MARGIN_SHIFT for every 16-bit t
    localparam int MARGIN_MUL_W = 17;
    localparam logic [MARGIN_MUL_W-1:0] MARGIN_MUL = 17'd83887;
    localparam int MARGIN_SHIFT = 24;

    localparam logic [PERIOD_W-1:0] PULSE_PERIOD_RESET = 20'd31250;
    localparam logic [TICK_W-1:0]   TICK_PERIOD_RESET  = 8'd4;
    localparam logic [TRIM_W-1:0]   TRIM_RESET         = 8'd191;
    localparam logic [TRIM_W-1:0]   TRIM_MIN           = 8'd128;
    localparam logic [TRIM_W-1:0]   TRIM_MAX           = 8'd255;

    localparam logic OP_START = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_PERIOD = 2'd0,
        CFG_TICK_PERIOD  = 2'd1,
        CFG_INITIAL_TRIM = 2'd2
    } t_cfg_index;

    typedef enum logic [STATUS_W-1:0] {
        END_IN_BAND    = 2'd0,
        END_TRIM_LIMIT = 2'd1,
        END_ROUNDS     = 2'd2
    } t_end_status;

    typedef struct packed {
        logic        start;
        logic        div_step;
        logic        margin_load;
        logic        band_load;
        logic        edge_latch;
        logic        width_load;
        logic        trim_dec;
        logic        trim_inc;
        logic        rounds_dec;
        logic        out_load;
        logic        out_busy;
        logic        out_fin;
        t_end_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic above;
        logic below;
        logic trim_gt_min;
        logic trim_lt_max;
        logic rounds_last;
        logic div_last;
    } t_dp_stat;

endpackage

### design/otc_dp.sv
// ----------------------------------------------------------------------------
// otc_dp
// Datapath: configuration registers, bit-serial target divider, band
// computation, edge/width measurement, trim and round counters, result
// payload register.
// ----------------------------------------------------------------------------
module otc_dp #(
    parameter int MAX_ROUNDS  = otc_pkg::MAX_ROUNDS_DEF,
    parameter int COUNT_WIDTH = otc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [otc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [otc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [COUNT_WIDTH-1:0]              i_timer_count,
    input  otc_pkg::t_dp_cmd                    i_cmd,
    output otc_pkg::t_dp_stat                   o_stat,
    output logic [otc_pkg::TRIM_W-1:0]          o_trim_value,
    output logic                                o_busy_res,
    output logic                                o_finished,
    output logic [otc_pkg::STATUS_W-1:0]        o_end_status,
    output logic [COUNT_WIDTH-1:0]              o_measured_width
);

    localparam int RW    = $clog2(MAX_ROUNDS + 1);
    localparam int CMP_W = (COUNT_WIDTH > otc_pkg::BAND_W) ? COUNT_WIDTH : otc_pkg::BAND_W;
    localparam int PROD_W = otc_pkg::TARGET_W + otc_pkg::MARGIN_MUL_W;

    logic [otc_pkg::PERIOD_W-1:0]  r_pulse_period;
    logic [otc_pkg::TICK_W-1:0]    r_tick_period;
    logic [otc_pkg::TRIM_W-1:0]    r_initial_trim;

    logic [otc_pkg::TICK_W-1:0]    r_div_rem;
    logic [otc_pkg::PERIOD_W-1:0]  r_div_quo;
    logic [otc_pkg::TICK_W-1:0]    r_div_den;
    logic [otc_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [otc_pkg::TICK_W:0]      div_trial;
    logic                          div_bit;
    logic [otc_pkg::TICK_W-1:0]    n_div_rem;

    logic [otc_pkg::TARGET_W-1:0]  target_sat;
    logic [PROD_W-1:0]             margin_prod;
    logic [otc_pkg::TARGET_W-1:0]  r_target;
    logic [otc_pkg::MARGIN_W-1:0]  r_margin;
    logic [otc_pkg::BAND_W-1:0]    r_band_high;
    logic [otc_pkg::TARGET_W-1:0]  r_band_low;

    logic [COUNT_WIDTH-1:0]        r_edge_start;
    logic [COUNT_WIDTH-1:0]        width;
    logic [COUNT_WIDTH-1:0]        r_last_width;
    logic [COUNT_WIDTH-1:0]        n_last_width;
    logic [otc_pkg::TRIM_W-1:0]    r_trim;
    logic [otc_pkg::TRIM_W-1:0]    n_trim;
    logic [RW-1:0]                 r_rounds;
    logic [RW-1:0]                 n_rounds;

    assign div_trial = {r_div_rem, r_div_quo[otc_pkg::PERIOD_W-1]};
    assign div_bit   = (div_trial >= {1'b0, r_div_den});
    assign n_div_rem = div_bit ? otc_pkg::TICK_W'(div_trial - {1'b0, r_div_den})
                               : div_trial[otc_pkg::TICK_W-1:0];

    assign target_sat  = (|r_div_quo[otc_pkg::PERIOD_W-1:otc_pkg::TARGET_W])
                         ? {otc_pkg::TARGET_W{1'b1}} : r_div_quo[otc_pkg::TARGET_W-1:0];
    assign margin_prod = PROD_W'(target_sat) * PROD_W'(otc_pkg::MARGIN_MUL);

    assign width = i_timer_count - r_edge_start;

    assign o_stat.above       = CMP_W'(width) > CMP_W'(r_band_high);
    assign o_stat.below       = CMP_W'(width) < CMP_W'(r_band_low);
    assign o_stat.trim_gt_min = r_trim > otc_pkg::TRIM_MIN;
    assign o_stat.trim_lt_max = r_trim < otc_pkg::TRIM_MAX;
    assign o_stat.rounds_last = r_rounds <= RW'(1);
    assign o_stat.div_last    = r_div_cnt == otc_pkg::DIV_CNT_W'(otc_pkg::PERIOD_W - 1);

    always_comb begin
        priority if (i_cmd.start) begin
            n_trim = r_initial_trim;
        end else if (i_cmd.trim_dec) begin
            n_trim = r_trim - otc_pkg::TRIM_W'(1);
        end else if (i_cmd.trim_inc) begin
            n_trim = r_trim + otc_pkg::TRIM_W'(1);
        end else begin
            n_trim = r_trim;
        end
        priority if (i_cmd.start) begin
            n_rounds = RW'(MAX_ROUNDS);
        end else if (i_cmd.rounds_dec) begin
            n_rounds = o_stat.rounds_last ? '0 : r_rounds - RW'(1);
        end else begin
            n_rounds = r_rounds;
        end
        n_last_width = i_cmd.width_load ? width : r_last_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_period <= otc_pkg::PULSE_PERIOD_RESET;
            r_tick_period  <= otc_pkg::TICK_PERIOD_RESET;
            r_initial_trim <= otc_pkg::TRIM_RESET;
            r_trim         <= otc_pkg::TRIM_RESET;
            r_rounds       <= '0;
            r_edge_start   <= '0;
            r_last_width   <= '0;
            r_band_high    <= '0;
            r_band_low     <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    otc_pkg::CFG_PULSE_PERIOD: r_pulse_period <= i_cfg_data;
                    otc_pkg::CFG_TICK_PERIOD:
                        r_tick_period <= i_cfg_data[otc_pkg::TICK_W-1:0];
                    otc_pkg::CFG_INITIAL_TRIM:
                        r_initial_trim <= i_cfg_data[otc_pkg::TRIM_W-1:0];
                    default: ;
                endcase
            end
            r_trim       <= n_trim;
            r_rounds     <= n_rounds;
            r_last_width <= n_last_width;
            if (i_cmd.start) begin
                r_edge_start <= '0;
            end else if (i_cmd.edge_latch) begin
                r_edge_start <= i_timer_count;
            end
            if (i_cmd.band_load) begin
                r_band_high <= otc_pkg::BAND_W'(r_target) + otc_pkg::BAND_W'(r_margin);
                r_band_low  <= r_target - otc_pkg::TARGET_W'(r_margin);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_div_rem <= '0;
            r_div_quo <= r_pulse_period;
            r_div_den <= r_tick_period;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_rem <= n_div_rem;
            r_div_quo <= {r_div_quo[otc_pkg::PERIOD_W-2:0], div_bit};
            r_div_cnt <= r_div_cnt + otc_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.margin_load) begin
            r_target <= target_sat;
            r_margin <= margin_prod[otc_pkg::MARGIN_SHIFT +: otc_pkg::MARGIN_W];
        end
        if (i_cmd.out_load) begin
            o_trim_value     <= n_trim;
            o_busy_res       <= i_cmd.out_busy;
            o_finished       <= i_cmd.out_fin;
            o_end_status     <= i_cmd.out_status;
            o_measured_width <= n_last_width;
        end
    end

endmodule

### design/otc_ctrl.sv
// ----------------------------------------------------------------------------
// otc_ctrl
// Controller: request handshakes, setup sequencer (divide, margin, band) and
// calibration phase machine; issues datapath commands.
// ----------------------------------------------------------------------------
module otc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  logic               i_operation,
    input  logic               i_pin_level,
    input  otc_pkg::t_dp_stat  i_stat,
    output otc_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_READY  = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_MARGIN = 4'b0100,
        ST_BAND   = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_WAIT_LOW  = 4'b0010,
        PH_WAIT_RISE = 4'b0100,
        PH_WAIT_FALL = 4'b1000
    } t_phase;

    t_state r_state;
    t_state n_state;
    t_phase r_phase;
    t_phase n_phase;
    logic   r_out_valid;
    logic   in_accept;
    logic   stepped;

    assign o_stall   = (r_state != ST_READY) || (r_out_valid && i_stall);
    assign in_accept = i_valid && !o_stall;
    assign o_valid   = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_phase = r_phase;
        stepped = 1'b0;
        unique case (r_state)
            ST_READY: ;
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_MARGIN;
                end
            end
            ST_MARGIN: begin
                o_cmd.margin_load = 1'b1;
                n_state = ST_BAND;
            end
            ST_BAND: begin
                o_cmd.band_load = 1'b1;
                n_state = ST_READY;
            end
            default: n_state = ST_READY;
        endcase
        if (in_accept) begin
            o_cmd.out_load = 1'b1;
            if (i_operation == otc_pkg::OP_START) begin
                o_cmd.start = 1'b1;
                n_phase = PH_WAIT_LOW;
                n_state = ST_DIV;
            end else begin
                unique case (r_phase)
                    PH_IDLE: ;
                    PH_WAIT_LOW: begin
                        if (!i_pin_level) begin
                            n_phase = PH_WAIT_RISE;
                        end
                    end
                    PH_WAIT_RISE: begin
                        if (i_pin_level) begin
                            o_cmd.edge_latch = 1'b1;
                            n_phase = PH_WAIT_FALL;
                        end
                    end
                    PH_WAIT_FALL: begin
                        if (!i_pin_level) begin
                            o_cmd.width_load = 1'b1;
                            priority if (i_stat.above && i_stat.trim_gt_min) begin
                                o_cmd.trim_dec = 1'b1;
                                stepped = 1'b1;
                            end else if (i_stat.below && i_stat.trim_lt_max) begin
                                o_cmd.trim_inc = 1'b1;
                                stepped = 1'b1;
                            end else begin
                                o_cmd.out_fin = 1'b1;
                                o_cmd.out_status = (i_stat.above || i_stat.below)
                                                   ? otc_pkg::END_TRIM_LIMIT
                                                   : otc_pkg::END_IN_BAND;
                            end
                            if (stepped) begin
                                o_cmd.rounds_dec = 1'b1;
                                if (i_stat.rounds_last) begin
                                    o_cmd.out_fin = 1'b1;
                                    o_cmd.out_status = otc_pkg::END_ROUNDS;
                                end
                            end
                            n_phase = o_cmd.out_fin ? PH_IDLE : PH_WAIT_LOW;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            o_cmd.out_busy = (n_phase != PH_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold off requests while the setup sequence runs
    a_start_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_operation == otc_pkg::OP_START) |=> o_stall)
        else $error("start request not followed by setup stall");

    a_fin_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_fin |=> (r_phase == PH_IDLE))
        else $error("calibration finished but phase not idle");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !i_stat.div_last) |=> (r_state == ST_DIV))
        else $error("divider left before last step");

    a_step_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rounds_dec |-> (o_cmd.trim_dec != o_cmd.trim_inc) && o_cmd.width_load)
        else $error("round counted without a single trim step");

endmodule

### design/oscillator_trim_calibrator_unit.sv
// ----------------------------------------------------------------------------
// oscillator_trim_calibrator_unit
// Every accepted request loads its result into the output register. Pin
// samples are taken one per cycle while o_stall is low.
// A start request stalls further requests through the setup sequence: 20 steps
// of the bit-serial target divider, one margin multiply and one band update.
// Reset (i_rst_n low, synchronous): idle, trim 191, config registers to defaults.
// ----------------------------------------------------------------------------
module oscillator_trim_calibrator_unit #(
    parameter int MAX_ROUNDS  = otc_pkg::MAX_ROUNDS_DEF,
    parameter int COUNT_WIDTH = otc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic                            i_pin_level,
    input  logic [COUNT_WIDTH-1:0]          i_timer_count,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [otc_pkg::TRIM_W-1:0]      o_trim_value,
    output logic                            o_busy_res,
    output logic                            o_finished,
    output logic [otc_pkg::STATUS_W-1:0]    o_end_status,
    output logic [COUNT_WIDTH-1:0]          o_measured_width,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [otc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [otc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    otc_pkg::t_dp_cmd  cmd;
    otc_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    otc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_operation (i_operation),
        .i_pin_level (i_pin_level),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    otc_dp #(
        .MAX_ROUNDS  (MAX_ROUNDS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_timer_count    (i_timer_count),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_trim_value     (o_trim_value),
        .o_busy_res       (o_busy_res),
        .o_finished       (o_finished),
        .o_end_status     (o_end_status),
        .o_measured_width (o_measured_width)
    );

endmodule

### verif/oscillator_trim_calibrator_unit_tb.sv
// ----------------------------------------------------------------------------
// oscillator_trim_calibrator_unit_tb
// Self-checking testbench for the oscillator trim calibrator. A short table of
// directed requests covers idle samples, counter wrap, band edges, restarts,
// trim limits and a zero tick period. Random calibration runs follow: pulse
// trains whose widths track the trim so most runs settle in band, plus
// runaway, band-edge and noise sequences, under random configurations.
// Each result is compared with its typed row or an in-bench calibration model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module oscillator_trim_calibrator_unit_tb;

    localparam int CLK_HALF = 10;
    localparam int START_SETTLE = 24;
    localparam int ITEM_GOAL = 1550;
    localparam int PERIOD_MAX = (1 << otc_pkg::PERIOD_W) - 1;
    localparam logic [otc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic OP_SAMPLE = 1'b0;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_WAIT_LOW  = 4'b0010,
        PH_WAIT_RISE = 4'b0100,
        PH_WAIT_FALL = 4'b1000
    } t_cal_phase;
    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [otc_pkg::TRIM_W-1:0] trim;
        logic                       busy;
        logic                       fin;
        otc_pkg::t_end_status       status;
        logic [15:0]                width;
    } t_trim_report;

    typedef struct {
        t_row_kind                       kind;
        logic                            op;
        logic                            pin;
        logic [15:0]                     cnt;
        logic [otc_pkg::CFG_IDX_W-1:0]   idx;
        logic [otc_pkg::CFG_DATA_W-1:0]  data;
        bit                              typed;
        t_trim_report                    want;
    } t_stim_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic                            i_operation;
    logic                            i_pin_level;
    logic [15:0]                     i_timer_count;
    logic                            o_valid;
    logic                            i_stall;
    logic [otc_pkg::TRIM_W-1:0]      o_trim_value;
    logic                            o_busy_res;
    logic                            o_finished;
    logic [otc_pkg::STATUS_W-1:0]    o_end_status;
    logic [15:0]                     o_measured_width;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [otc_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [otc_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    // model state
    logic [otc_pkg::PERIOD_W-1:0] cfg_period;
    logic [otc_pkg::TICK_W-1:0]   cfg_tick;
    logic [otc_pkg::TRIM_W-1:0]   cfg_trim0;
    t_cal_phase                   cal_phase;
    logic [15:0]                  cal_edge;
    logic [otc_pkg::TRIM_W-1:0]   cal_trim;
    int                           cal_rounds;
    int unsigned                  band_hi;
    int unsigned                  band_lo;
    logic [15:0]                  cal_width;

    t_trim_report expected_reports[$];
    t_stim_row    dir_tab[$];
    int unsigned  errors;
    int unsigned  items_sent;
    int           rx_hold_req;
    bit           quiet;

    oscillator_trim_calibrator_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_pin_level      (i_pin_level),
        .i_timer_count    (i_timer_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_trim_value     (o_trim_value),
        .o_busy_res       (o_busy_res),
        .o_finished       (o_finished),
        .o_end_status     (o_end_status),
        .o_measured_width (o_measured_width),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin
        #(10_000_000);
        $display("** oscillator_trim_calibrator_unit: FAILED **");
        $finish;
    end

    function automatic void calib_reset();
        cfg_period = otc_pkg::PULSE_PERIOD_RESET;
        cfg_tick   = otc_pkg::TICK_PERIOD_RESET;
        cfg_trim0  = otc_pkg::TRIM_RESET;
        cal_phase  = PH_IDLE;
        cal_edge   = '0;
        cal_trim   = otc_pkg::TRIM_RESET;
        cal_rounds = 0;
        band_hi    = 0;
        band_lo    = 0;
        cal_width  = '0;
    endfunction

    function automatic t_trim_report calibrate_item(logic op, logic pin, logic [15:0] cnt);
        int unsigned          tgt;
        int unsigned          mgn;
        logic [15:0]          w;
        logic                 fin;
        logic                 stepped;
        otc_pkg::t_end_status st;
        t_trim_report         r;
        fin = 1'b0;
        stepped = 1'b0;
        st = otc_pkg::END_IN_BAND;
        if (op == otc_pkg::OP_START) begin
            if (cfg_tick == 0) tgt = 65535;
            else tgt = cfg_period / cfg_tick;
            if (tgt > 65535) tgt = 65535;
            mgn = tgt / 200;
            band_hi = tgt + mgn;
            band_lo = tgt - mgn;
            cal_trim = cfg_trim0;
            cal_rounds = otc_pkg::MAX_ROUNDS_DEF;
            cal_edge = '0;
            cal_phase = PH_WAIT_LOW;
        end else begin
            unique case (cal_phase)
                PH_WAIT_LOW: if (!pin) cal_phase = PH_WAIT_RISE;
                PH_WAIT_RISE: if (pin) begin
                    cal_edge = cnt;
                    cal_phase = PH_WAIT_FALL;
                end
                PH_WAIT_FALL: if (!pin) begin
                    w = cnt - cal_edge;
                    cal_width = w;
                    if (w > band_hi && cal_trim > otc_pkg::TRIM_MIN) begin
                        cal_trim = cal_trim - 1'b1;
                        stepped = 1'b1;
                    end else if (w < band_lo && cal_trim < otc_pkg::TRIM_MAX) begin
                        cal_trim = cal_trim + 1'b1;
                        stepped = 1'b1;
                    end else begin
                        fin = 1'b1;
                        st = (w > band_hi || w < band_lo) ? otc_pkg::END_TRIM_LIMIT
                                                          : otc_pkg::END_IN_BAND;
                    end
                    if (stepped) begin
                        if (cal_rounds <= 1) begin
                            cal_rounds = 0;
                            fin = 1'b1;
                            st = otc_pkg::END_ROUNDS;
                        end else begin
                            cal_rounds = cal_rounds - 1;
                        end
                    end
                    cal_phase = fin ? PH_IDLE : PH_WAIT_LOW;
                end
                default: ;
            endcase
        end
        r.trim   = cal_trim;
        r.busy   = (cal_phase != PH_IDLE);
        r.fin    = fin;
        r.status = st;
        r.width  = cal_width;
        return r;
    endfunction

    function automatic t_stim_row item_row(logic op, logic pin, logic [15:0] cnt, bit typed,
                                           logic [7:0] trim, logic busy, logic fin,
                                           otc_pkg::t_end_status st, logic [15:0] w);
        t_stim_row r;
        r.kind = ROW_ITEM;
        r.op = op;
        r.pin = pin;
        r.cnt = cnt;
        r.idx = otc_pkg::CFG_PULSE_PERIOD;
        r.data = '0;
        r.typed = typed;
        r.want.trim = trim;
        r.want.busy = busy;
        r.want.fin = fin;
        r.want.status = st;
        r.want.width = w;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(logic [otc_pkg::CFG_IDX_W-1:0] idx,
                                          logic [otc_pkg::CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = item_row(OP_SAMPLE, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0, otc_pkg::END_IN_BAND, '0);
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    task automatic send_item(input logic op, input logic pin, input logic [15:0] cnt,
                             input bit typed, input t_trim_report want);
        t_trim_report pred;
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_pin_level <= pin;
        i_timer_count <= cnt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = calibrate_item(op, pin, cnt);
        expected_reports.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic send_sample(input logic op, input logic pin, input logic [15:0] cnt);
        send_item(op, pin, cnt, 1'b0, '0);
    endtask

    // drop the request and wait for the block to go quiet
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (START_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [otc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [otc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        unique case (idx)
            otc_pkg::CFG_PULSE_PERIOD: cfg_period = data[otc_pkg::PERIOD_W-1:0];
            otc_pkg::CFG_TICK_PERIOD:  cfg_tick = data[otc_pkg::TICK_W-1:0];
            otc_pkg::CFG_INITIAL_TRIM: cfg_trim0 = data[otc_pkg::TRIM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic pick_config();
        logic [otc_pkg::PERIOD_W-1:0]   per;
        logic [otc_pkg::TICK_W-1:0]     tk;
        logic [otc_pkg::TRIM_W-1:0]     tr;
        logic [otc_pkg::CFG_DATA_W-1:0] junk;
        longint                         p;
        int                             k;
        int                             first;
        k = $urandom_range(0, 99);
        if (k < 5) tk = 8'd0;
        else if (k < 10) tk = 8'd1;
        else if (k < 15) tk = 8'd255;
        else tk = 8'($urandom_range(1, 255));
        k = $urandom_range(0, 99);
        if (k < 4) per = '0;
        else if (k < 8) per = 20'd1;
        else if (k < 12) per = PERIOD_MAX[otc_pkg::PERIOD_W-1:0];
        else if (k < 16) per = otc_pkg::PULSE_PERIOD_RESET;
        else if (k < 30) per = otc_pkg::PERIOD_W'($urandom_range(0, PERIOD_MAX));
        else begin
            p = longint'(tk) * longint'($urandom_range(1, 20000))
                + longint'($urandom_range(0, 255));
            if (p > PERIOD_MAX) p = PERIOD_MAX;
            per = otc_pkg::PERIOD_W'(p);
        end
        k = $urandom_range(0, 99);
        if (k < 4) tr = 8'd0;
        else if (k < 8) tr = 8'd127;
        else if (k < 12) tr = otc_pkg::TRIM_MIN;
        else if (k < 16) tr = otc_pkg::TRIM_MAX;
        else tr = 8'($urandom_range(128, 255));
        junk = otc_pkg::CFG_DATA_W'($urandom);
        settle();
        first = $urandom_range(0, 2);
        for (int j = 0; j < 3; j++) begin
            unique case ((first + j) % 3)
                0: write_reg(otc_pkg::CFG_PULSE_PERIOD, per);
                1: write_reg(otc_pkg::CFG_TICK_PERIOD,
                             {junk[otc_pkg::CFG_DATA_W-1:otc_pkg::TICK_W], tk});
                default: write_reg(otc_pkg::CFG_INITIAL_TRIM,
                                   {junk[otc_pkg::CFG_DATA_W-1:otc_pkg::TRIM_W], tr});
            endcase
        end
        if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, otc_pkg::CFG_DATA_W'($urandom));
    endtask

    task automatic run_sequence();
        int          mode;
        int          goal;
        int          slope;
        int          tgt;
        int          mgn;
        int          w;
        int          guard;
        int          k;
        bit          runaway_up;
        logic [15:0] t0;
        mode = $urandom_range(0, 99);
        goal = int'(cfg_trim0) + int'($urandom_range(0, 16)) - 8;
        runaway_up = $urandom_range(0, 1);
        send_sample(otc_pkg::OP_START, 1'($urandom), 16'($urandom));
        tgt = int'((band_hi + band_lo) / 2);
        mgn = int'((band_hi - band_lo) / 2);
        slope = int'($urandom_range(1, 2 * mgn + 1));
        guard = 0;
        while (cal_phase != PH_IDLE && guard < 80) begin
            if ($urandom_range(0, 99) < 4) begin
                send_sample(($urandom_range(0, 4) == 0) ? otc_pkg::OP_START : OP_SAMPLE,
                            1'($urandom), 16'($urandom));
            end
            if (mode >= 3) begin
                repeat ($urandom_range(0, 2)) send_sample(OP_SAMPLE, 1'b1, 16'($urandom));
            end
            repeat ($urandom_range(1, 2)) send_sample(OP_SAMPLE, 1'b0, 16'($urandom));
            t0 = 16'($urandom);
            send_sample(OP_SAMPLE, 1'b1, t0);
            if (mode >= 3) begin
                repeat ($urandom_range(0, 2)) send_sample(OP_SAMPLE, 1'b1, 16'($urandom));
            end
            if (mode < 3) begin
                w = runaway_up ? 0 : 65535;
            end else if (mode < 75) begin
                w = tgt + (int'(cal_trim) - goal) * slope
                    + int'($urandom_range(0, 2 * mgn)) - mgn;
            end else begin
                k = $urandom_range(0, 5);
                unique case (k)
                    0: w = int'(band_lo) - 1;
                    1: w = int'(band_lo);
                    2: w = int'(band_hi);
                    3: w = int'(band_hi) + 1;
                    4: w = tgt;
                    default: w = int'($urandom_range(0, 65535));
                endcase
            end
            if (w < 0) w = 0;
            if (w > 65535) w = 65535;
            send_sample(OP_SAMPLE, 1'b0, t0 + 16'(w));
            guard++;
        end
        repeat ($urandom_range(0, 1)) send_sample(OP_SAMPLE, 1'($urandom), 16'($urandom));
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= !quiet && ($urandom_range(0, 99) < 7);
            end
        end
    end

    always @(posedge i_clk) begin
        t_trim_report got;
        t_trim_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.trim = o_trim_value;
            got.busy = o_busy_res;
            got.fin = o_finished;
            got.status = otc_pkg::t_end_status'(o_end_status);
            got.width = o_measured_width;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: trim %0d width %0d",
                                           got.trim, got.width);
            end else begin
                want = expected_reports.pop_front();
                if (got.trim !== want.trim || got.busy !== want.busy ||
                    got.fin !== want.fin || got.status !== want.status ||
                    got.width !== want.width) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp trim %0d busy %0d fin %0d status %0d width %0d",
                                 want.trim, want.busy, want.fin, want.status, want.width);
                        $display("          got trim %0d busy %0d fin %0d status %0d width %0d",
                                 got.trim, got.busy, got.fin, got.status, got.width);
                    end
                end
            end
        end
    end

    initial begin
        int          phase_no;
        int          seq_left;
        int          spins;
        t_stim_row   row;
        errors = 0;
        items_sent = 0;
        rx_hold_req = 0;
        quiet = 1'b0;
        calib_reset();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_operation <= OP_SAMPLE;
        i_pin_level <= 1'b0;
        i_timer_count <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= otc_pkg::CFG_PULSE_PERIOD;
        i_cfg_data <= '0;

        dir_tab.push_back(item_row(OP_SAMPLE, 1, 16'hFFFF, 1, 191, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(otc_pkg::OP_START, 0, 16'h0000, 1, 191, 1, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 1, 16'h0000, 1, 191, 1, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'h0000, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 1, 16'hFFF0, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'h1E74, 1, 191, 0, 1,
                                   otc_pkg::END_IN_BAND, 7812));
        dir_tab.push_back(item_row(otc_pkg::OP_START, 1, 16'hFFFF, 1, 191, 1, 0,
                                   otc_pkg::END_IN_BAND, 7812));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'h1234, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 1, 16'd100, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'd100, 1, 192, 1, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(otc_pkg::OP_START, 1, 16'hAAAA, 1, 191, 1, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'h5555, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 1, 16'h0000, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'hFFFF, 1, 190, 1, 0,
                                   otc_pkg::END_IN_BAND, 65535));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'h0000, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 1, 16'd10, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'd7861, 1, 190, 0, 1,
                                   otc_pkg::END_IN_BAND, 7851));
        dir_tab.push_back(cfg_row(otc_pkg::CFG_INITIAL_TRIM, 20'd255));
        dir_tab.push_back(item_row(otc_pkg::OP_START, 0, 16'h0000, 1, 255, 1, 0,
                                   otc_pkg::END_IN_BAND, 7851));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'h0000, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 1, 16'h0000, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'h0001, 1, 255, 0, 1,
                                   otc_pkg::END_TRIM_LIMIT, 1));
        dir_tab.push_back(cfg_row(otc_pkg::CFG_TICK_PERIOD, 20'd0));
        dir_tab.push_back(cfg_row(otc_pkg::CFG_INITIAL_TRIM, 20'd128));
        dir_tab.push_back(item_row(otc_pkg::OP_START, 0, 16'h0000, 1, 128, 1, 0,
                                   otc_pkg::END_IN_BAND, 1));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'h0000, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 1, 16'h0000, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'hFFFF, 1, 128, 0, 1,
                                   otc_pkg::END_IN_BAND, 65535));
        dir_tab.push_back(cfg_row(otc_pkg::CFG_TICK_PERIOD, 20'd1));
        dir_tab.push_back(cfg_row(otc_pkg::CFG_PULSE_PERIOD, 20'd200));
        dir_tab.push_back(item_row(otc_pkg::OP_START, 0, 16'h0000, 1, 128, 1, 0,
                                   otc_pkg::END_IN_BAND, 65535));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'h0000, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 1, 16'h0000, 0, 0, 0, 0,
                                   otc_pkg::END_IN_BAND, 0));
        dir_tab.push_back(item_row(OP_SAMPLE, 0, 16'd202, 1, 128, 0, 1,
                                   otc_pkg::END_TRIM_LIMIT, 202));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[n]) begin
            row = dir_tab[n];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.idx, row.data);
            end else begin
                send_item(row.op, row.pin, row.cnt, row.typed, row.want);
            end
        end

        phase_no = 0;
        while (items_sent < ITEM_GOAL) begin
            pick_config();
            quiet = (phase_no == 2);
            if (phase_no == 1) rx_hold_req = 80;
            seq_left = $urandom_range(3, 8);
            while (seq_left > 0 && items_sent < ITEM_GOAL) begin
                run_sequence();
                seq_left--;
            end
            phase_no++;
        end
        quiet = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;
        spins = 0;
        while (expected_reports.size() != 0 && spins < 20000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (START_SETTLE) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            errors++;
            $display("%0d results never arrived", expected_reports.size());
        end
        if (errors == 0) begin
            $display("** oscillator_trim_calibrator_unit: PASSED **");
        end else begin
            $display("** oscillator_trim_calibrator_unit: FAILED **");
        end
        $finish;
    end

endmodule
